// File: rtl/crc8fr_pkg.sv
// crc8fr_pkg: shared types, codes and the crc-8 byte update for the frame receiver
// used by every module under rtl; depends on nothing
package crc8fr_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned SYNC_W    = 16;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned RSP_W     = 48;

   localparam logic [CSR_IDX_W-1:0] REG_SYNC_WORD        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CRC_POLYNOMIAL   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HANDSHAKE_ID     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HEARTBEAT_ID     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_VELOCITY_ID      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_HANDSHAKE_LENGTH = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_HEARTBEAT_LENGTH = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_VELOCITY_LENGTH  = 3'd7;

   localparam logic [SYNC_W-1:0] RST_SYNC_WORD        = 16'hAA55;
   localparam logic [BYTE_W-1:0] RST_CRC_POLYNOMIAL   = 8'h07;
   localparam logic [BYTE_W-1:0] RST_HANDSHAKE_ID     = 8'd1;
   localparam logic [BYTE_W-1:0] RST_HEARTBEAT_ID     = 8'd2;
   localparam logic [BYTE_W-1:0] RST_VELOCITY_ID      = 8'd3;
   localparam logic [BYTE_W-1:0] RST_HANDSHAKE_LENGTH = 8'd4;
   localparam logic [BYTE_W-1:0] RST_HEARTBEAT_LENGTH = 8'd4;
   localparam logic [BYTE_W-1:0] RST_VELOCITY_LENGTH  = 8'd12;

   localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
   localparam logic [1:0] KIND_ACCEPT   = 2'd1;
   localparam logic [1:0] KIND_MISMATCH = 2'd2;

   localparam logic [1:0] CLASS_NONE      = 2'd0;
   localparam logic [1:0] CLASS_HANDSHAKE = 2'd1;
   localparam logic [1:0] CLASS_HEARTBEAT = 2'd2;
   localparam logic [1:0] CLASS_VELOCITY  = 2'd3;

   typedef enum logic [2:0] {
      PH_SYNC1  = 3'd0,
      PH_SYNC2  = 3'd1,
      PH_ID     = 3'd2,
      PH_LENGTH = 3'd3,
      PH_DATA   = 3'd4,
      PH_CRC    = 3'd5
   } phase_type;

   typedef struct packed {
      logic [SYNC_W-1:0] sync_word;
      logic [BYTE_W-1:0] crc_polynomial;
      logic [BYTE_W-1:0] handshake_id;
      logic [BYTE_W-1:0] heartbeat_id;
      logic [BYTE_W-1:0] velocity_id;
      logic [BYTE_W-1:0] handshake_length;
      logic [BYTE_W-1:0] heartbeat_length;
      logic [BYTE_W-1:0] velocity_length;
   } cfg_type;

   typedef struct packed {
      logic [1:0]        result_kind;
      logic [BYTE_W-1:0] payload_byte;
      logic [BYTE_W-1:0] payload_index;
      logic [BYTE_W-1:0] frame_id;
      logic [BYTE_W-1:0] frame_length;
      logic [1:0]        packet_class;
      logic              reply_due;
      logic [BYTE_W-1:0] computed_crc;
   } result_type;

   // msb-first crc-8 over one byte, implicit x^8 term
   function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                     input logic [BYTE_W-1:0] data,
                                                     input logic [BYTE_W-1:0] poly);
      logic [BYTE_W-1:0] c;
      c = crc ^ data;
      for (int i = 0; i < BYTE_W; i++) begin
         if (c[BYTE_W-1]) begin
            c = {c[BYTE_W-2:0], 1'b0} ^ poly;
         end else begin
            c = {c[BYTE_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// File: rtl/crc8_frame_receiver_top.sv
// crc8_frame_receiver_top: byte-stream frame receiver with crc-8 check
// depends on crc8fr_pkg, crc8fr_csr, crc8fr_parser, crc8fr_out_buf
//
// req_ carries one received byte per request. The parser hunts for the two sync
// bytes, then takes id, length, the payload and a crc byte. Each payload byte
// gives one response with its index and the running crc; the crc byte gives a
// verdict response (accepted with class and reply flag, or crc mismatch).
// Sync, id and length bytes give no response.
// A response is registered in the response buffer before it appears on rsp_.
// Throughput: one byte per cycle while the buffer has space; the crc step and
// phase update sit between the request handshake and a two-entry response buffer.
// req_tready drops only while both buffer entries hold responses not yet taken,
// so a stalled rsp_ side holds back requests after two responses.
// csr_ writes take effect on the next cycle and are meant for idle periods.
// Reset (synchronous) restores the register defaults, returns the parser to
// the sync hunt and empties the response buffer.
module crc8_frame_receiver_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [crc8fr_pkg::BYTE_W-1:0]        req_tdata,  // rx_byte
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // result_kind, payload_byte, payload_index, frame_id, frame_length,
   // packet_class, reply_due, computed_crc, zero fill
   output logic [crc8fr_pkg::RSP_W-1:0]         rsp_tdata,
   input  logic                                 csr_we,
   input  logic [crc8fr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [crc8fr_pkg::SYNC_W-1:0]        csr_wdata
);
   import crc8fr_pkg::*;

   cfg_type    cfg;
   logic       accept;
   logic       res_valid;
   result_type res;
   result_type out_res;
   logic       buf_space;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = buf_space;

   crc8fr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   crc8fr_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rx_byte   (req_tdata),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res)
   );

   crc8fr_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .has_space (buf_space),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_res)
   );

   assign rsp_tdata = {3'b000,
                       out_res.computed_crc,
                       out_res.reply_due,
                       out_res.packet_class,
                       out_res.frame_length,
                       out_res.frame_id,
                       out_res.payload_index,
                       out_res.payload_byte,
                       out_res.result_kind};

endmodule

// File: rtl/crc8fr_csr.sv
// crc8fr_csr: configuration registers of the frame receiver, write-only
// depends on crc8fr_pkg
module crc8fr_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [crc8fr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [crc8fr_pkg::SYNC_W-1:0]         csr_wdata,
   output crc8fr_pkg::cfg_type                   cfg
);
   import crc8fr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_SYNC_WORD:        cfg_in.sync_word        = csr_wdata;
            REG_CRC_POLYNOMIAL:   cfg_in.crc_polynomial   = csr_wdata[BYTE_W-1:0];
            REG_HANDSHAKE_ID:     cfg_in.handshake_id     = csr_wdata[BYTE_W-1:0];
            REG_HEARTBEAT_ID:     cfg_in.heartbeat_id     = csr_wdata[BYTE_W-1:0];
            REG_VELOCITY_ID:      cfg_in.velocity_id      = csr_wdata[BYTE_W-1:0];
            REG_HANDSHAKE_LENGTH: cfg_in.handshake_length = csr_wdata[BYTE_W-1:0];
            REG_HEARTBEAT_LENGTH: cfg_in.heartbeat_length = csr_wdata[BYTE_W-1:0];
            REG_VELOCITY_LENGTH:  cfg_in.velocity_length  = csr_wdata[BYTE_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_word        <= RST_SYNC_WORD;
         cfg_ff.crc_polynomial   <= RST_CRC_POLYNOMIAL;
         cfg_ff.handshake_id     <= RST_HANDSHAKE_ID;
         cfg_ff.heartbeat_id     <= RST_HEARTBEAT_ID;
         cfg_ff.velocity_id      <= RST_VELOCITY_ID;
         cfg_ff.handshake_length <= RST_HANDSHAKE_LENGTH;
         cfg_ff.heartbeat_length <= RST_HEARTBEAT_LENGTH;
         cfg_ff.velocity_length  <= RST_VELOCITY_LENGTH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/crc8fr_parser.sv
// crc8fr_parser: frame fsm, running crc and result forming, one byte per accepted cycle
// depends on crc8fr_pkg
module crc8fr_parser (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic [crc8fr_pkg::BYTE_W-1:0]    rx_byte,
   input  crc8fr_pkg::cfg_type              cfg,
   output logic                             res_valid,
   output crc8fr_pkg::result_type           res
);
   import crc8fr_pkg::*;

   phase_type         phase_ff, phase_in;
   logic [BYTE_W-1:0] held_id_ff, held_id_in;
   logic [BYTE_W-1:0] held_length_ff, held_length_in;
   logic [BYTE_W-1:0] bytes_taken_ff, bytes_taken_in;
   logic [BYTE_W-1:0] running_crc_ff, running_crc_in;

   logic [BYTE_W-1:0] crc_base;
   logic [BYTE_W-1:0] crc_next;
   logic [BYTE_W-1:0] taken_inc;
   logic [1:0]        class_code;

   assign crc_base  = (phase_ff == PH_ID) ? '0 : running_crc_ff;
   assign crc_next  = crc8_update(crc_base, rx_byte, cfg.crc_polynomial);
   assign taken_inc = bytes_taken_ff + 8'd1;

   // first matching id decides, even on a length mismatch
   always_comb begin
      if (held_id_ff == cfg.handshake_id) begin
         class_code = (held_length_ff == cfg.handshake_length) ? CLASS_HANDSHAKE : CLASS_NONE;
      end else if (held_id_ff == cfg.heartbeat_id) begin
         class_code = (held_length_ff == cfg.heartbeat_length) ? CLASS_HEARTBEAT : CLASS_NONE;
      end else if (held_id_ff == cfg.velocity_id) begin
         class_code = (held_length_ff == cfg.velocity_length) ? CLASS_VELOCITY : CLASS_NONE;
      end else begin
         class_code = CLASS_NONE;
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         case (phase_ff)
            PH_SYNC1:  phase_in = (rx_byte == cfg.sync_word[SYNC_W-1:BYTE_W]) ? PH_SYNC2
                                                                              : PH_SYNC1;
            PH_SYNC2:  phase_in = (rx_byte == cfg.sync_word[BYTE_W-1:0]) ? PH_ID : PH_SYNC1;
            PH_ID:     phase_in = PH_LENGTH;
            PH_LENGTH: phase_in = (rx_byte != '0) ? PH_DATA : PH_CRC;
            PH_DATA:   phase_in = (taken_inc >= held_length_ff) ? PH_CRC : PH_DATA;
            PH_CRC:    phase_in = PH_SYNC1;
            default:   phase_in = PH_SYNC1;
         endcase
      end
   end

   // datapath state and result
   always_comb begin
      held_id_in     = held_id_ff;
      held_length_in = held_length_ff;
      bytes_taken_in = bytes_taken_ff;
      running_crc_in = running_crc_ff;
      res_valid      = 1'b0;
      res            = '0;
      if (accept) begin
         case (phase_ff)
            PH_SYNC1: begin
               if (rx_byte == cfg.sync_word[SYNC_W-1:BYTE_W]) begin
                  running_crc_in = '0;
               end
            end
            PH_ID: begin
               held_id_in     = rx_byte;
               running_crc_in = crc_next;
            end
            PH_LENGTH: begin
               held_length_in = rx_byte;
               running_crc_in = crc_next;
               bytes_taken_in = '0;
            end
            PH_DATA: begin
               running_crc_in    = crc_next;
               bytes_taken_in    = taken_inc;
               res_valid         = 1'b1;
               res.result_kind   = KIND_PAYLOAD;
               res.payload_byte  = rx_byte;
               res.payload_index = bytes_taken_ff;
               res.frame_id      = held_id_ff;
               res.frame_length  = held_length_ff;
               res.computed_crc  = crc_next;
            end
            PH_CRC: begin
               res_valid        = 1'b1;
               res.frame_id     = held_id_ff;
               res.frame_length = held_length_ff;
               res.computed_crc = running_crc_ff;
               if (rx_byte == running_crc_ff) begin
                  res.result_kind  = KIND_ACCEPT;
                  res.packet_class = class_code;
                  res.reply_due    = 1'b1;
               end else begin
                  res.result_kind = KIND_MISMATCH;
               end
            end
            default: begin
               res_valid = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_SYNC1;
         held_id_ff     <= '0;
         held_length_ff <= '0;
         bytes_taken_ff <= '0;
         running_crc_ff <= '0;
      end else begin
         phase_ff       <= phase_in;
         held_id_ff     <= held_id_in;
         held_length_ff <= held_length_in;
         bytes_taken_ff <= bytes_taken_in;
         running_crc_ff <= running_crc_in;
      end
   end

   a_data_index_in_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> bytes_taken_ff < held_length_ff)
      else $error("payload index ran past the declared length");

   a_verdict_ends_frame: assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == PH_CRC |=> phase_ff == PH_SYNC1)
      else $error("parser did not return to sync hunt after the crc byte");

   a_result_only_in_body: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> accept && (phase_ff == PH_DATA || phase_ff == PH_CRC))
      else $error("result raised outside payload or crc phase");

endmodule

// File: rtl/crc8fr_out_buf.sv
// crc8fr_out_buf: two-entry result buffer that decouples the parser from response stalls
// depends on crc8fr_pkg
module crc8fr_out_buf (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  crc8fr_pkg::result_type     push_data,
   output logic                       has_space,
   output logic                       out_valid,
   input  logic                       out_ready,
   output crc8fr_pkg::result_type     out_data
);
   import crc8fr_pkg::*;

   result_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign out_valid = (count_ff != 2'd0);
   assign has_space = (count_ff != 2'd2);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result buffer count out of range");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> has_space)
      else $error("result pushed into a full buffer");

   a_ptrs_track_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("buffer pointers disagree with fill count");

endmodule
